[rtl/core/tffc_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tffc_pkg
// Shared types, codes and colour conversion helpers for the texel fetch block.
// ----------------------------------------------------------------------------
package tffc_pkg;

	localparam int TFFC_TMEM_BYTES_DEF = 4096;

	// configuration register indexes
	localparam logic [1:0] CFG_TILE_BASE     = 2'd0;
	localparam logic [1:0] CFG_TILE_STRIDE   = 2'd1;
	localparam logic [1:0] CFG_TILE_FORMAT   = 2'd2;
	localparam logic [1:0] CFG_DEFAULT_COLOR = 2'd3;

	// tile format codes
	localparam logic [4:0] FMT_RGBA16 = 5'd2;
	localparam logic [4:0] FMT_RGBA32 = 5'd3;
	localparam logic [4:0] FMT_CI4    = 5'd8;
	localparam logic [4:0] FMT_CI8    = 5'd9;
	localparam logic [4:0] FMT_IA4    = 5'd12;
	localparam logic [4:0] FMT_IA8    = 5'd13;
	localparam logic [4:0] FMT_I4     = 5'd16;
	localparam logic [4:0] FMT_I8     = 5'd17;

	// write sizes
	localparam logic [1:0] WSIZE_1 = 2'd0;
	localparam logic [1:0] WSIZE_2 = 2'd1;
	localparam logic [1:0] WSIZE_4 = 2'd2;

	// per-fetch control carried from the address stage to the converter
	typedef struct packed {
		logic [4:0] fmt;
		logic       s_odd;
	} tffc_fetch_t;

	// floor(v*255/31): reciprocal multiply, 255*ceil(2^20/31) folded into one constant
	function automatic logic [7:0] exp5(input logic [4:0] v);
		logic [31:0] p;
		p = 32'(v) * 32'd8625630;
		return p[27:20];
	endfunction

	// floor(v*255/7): 255*ceil(2^16/7)
	function automatic logic [7:0] exp3(input logic [2:0] v);
		logic [31:0] p;
		p = 32'(v) * 32'd2387565;
		return p[23:16];
	endfunction

	// floor(v*255/15) is exactly v*17
	function automatic logic [7:0] exp4(input logic [3:0] v);
		return {v, v};
	endfunction

	// floor(c*31/255): 31*ceil(2^24/255)
	function automatic logic [4:0] red5(input logic [7:0] c);
		logic [31:0] p;
		p = 32'(c) * 32'd2039614;
		return p[28:24];
	endfunction

	function automatic logic [15:0] pack16(input logic [31:0] c);
		return {red5(c[31:24]), red5(c[23:16]), red5(c[15:8]), 1'b0} | 16'(c[7:0] != 8'd0);
	endfunction

	function automatic logic [31:0] grey(input logic [7:0] i, input logic [7:0] a);
		return {i, i, i, a};
	endfunction

endpackage
`default_nettype wire

[rtl/core/tffc_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tffc_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module tffc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  wire                      clk,
	input  wire                      we,
	input  wire [$clog2(DEPTH)-1:0]  waddr,
	input  wire [WIDTH-1:0]          wdata,
	input  wire                      re,
	input  wire [$clog2(DEPTH)-1:0]  raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

[rtl/core/tffc_tmem.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tffc_tmem
// Texture memory as four byte lanes; unaligned wrapping reads of up to four
// bytes in one access, aligned byte-enabled writes, clearing pass after reset.
// ----------------------------------------------------------------------------
module tffc_tmem import tffc_pkg::*; #(
	parameter int TMEM_BYTES = TFFC_TMEM_BYTES_DEF
) (
	input  wire                            clk,
	input  wire                            arst_n,
	output logic                           busy,
	input  wire                            wr_en,
	input  wire [$clog2(TMEM_BYTES)-1:0]   wr_addr,
	input  wire [1:0]                      wr_size,
	input  wire [31:0]                     wr_data,
	input  wire                            rd_en,
	input  wire [$clog2(TMEM_BYTES)-1:0]   rd_addr,
	output logic [31:0]                    rd_data
);

	localparam int AW   = $clog2(TMEM_BYTES);
	localparam int ROWS = TMEM_BYTES / 4;
	localparam int RW   = $clog2(ROWS);

	logic          busy_q;
	logic [RW-1:0] clr_row_q;
	logic [1:0]    off_q;
	logic [AW-1:0] wa;
	logic [7:0]    lane_rd [4];

	assign busy = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b1;
			clr_row_q <= '0;
		end else if (busy_q) begin
			clr_row_q <= clr_row_q + RW'(1);
			if (clr_row_q == RW'(ROWS - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// byte offset of the first byte read, selects the lane rotation
	always_ff @(posedge clk) begin
		if (rd_en) begin
			off_q <= rd_addr[1:0];
		end
	end

	always_comb begin
		wa = wr_addr;
		case (wr_size)
			WSIZE_2: wa[0]   = 1'b0;
			WSIZE_4: wa[1:0] = 2'b00;
			default: ;
		endcase
	end

	for (genvar L = 0; L < 4; L++) begin : g_lane
		logic          we_l;
		logic [1:0]    k;
		logic [RW-1:0] wrow;
		logic [RW-1:0] rrow;
		logic [7:0]    wd;
		logic [31:0]   sh;

		assign k  = 2'(L) - wa[1:0];
		assign sh = wr_data >> {k, 3'b000};

		always_comb begin
			case (wr_size)
				WSIZE_1: we_l = wr_en && (wa[1:0] == 2'(L));
				WSIZE_2: we_l = wr_en && (wa[1] == 1'(L >> 1));
				WSIZE_4: we_l = wr_en;
				default: we_l = 1'b0;
			endcase
		end

		// lanes below the start offset hold bytes of the next row
		assign rrow = RW'(rd_addr[AW-1:2] + RW'(2'(L) < rd_addr[1:0]));
		assign wrow = busy_q ? clr_row_q : wa[AW-1:2];
		assign wd   = busy_q ? 8'd0 : sh[7:0];

		tffc_ram #(.WIDTH(8), .DEPTH(ROWS)) u_ram (
			.clk   (clk),
			.we    (busy_q || we_l),
			.waddr (wrow),
			.wdata (wd),
			.re    (rd_en),
			.raddr (rrow),
			.rdata (lane_rd[L])
		);
	end

	always_comb begin
		for (int b = 0; b < 4; b++) begin
			rd_data[8*b +: 8] = lane_rd[2'(off_q + 2'(b))];
		end
	end

endmodule
`default_nettype wire

[rtl/core/tffc_conv.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tffc_conv
// Texel format decode and expansion to RGBA32.
// ----------------------------------------------------------------------------
module tffc_conv import tffc_pkg::*; (
	input  wire [31:0]  bytes,
	input  tffc_fetch_t fetch,
	input  wire [31:0]  default_color,
	output logic [31:0] color,
	output logic        unknown
);

	logic [15:0] v16;
	logic [3:0]  nib;

	assign v16 = bytes[15:0];
	// even s takes the high nibble
	assign nib = fetch.s_odd ? bytes[3:0] : bytes[7:4];

	always_comb begin
		unknown = 1'b0;
		case (fetch.fmt)
			FMT_RGBA16: color = {exp5(v16[15:11]), exp5(v16[10:6]), exp5(v16[5:1]),
				{8{v16[0]}}};
			FMT_RGBA32: color = bytes;
			FMT_IA4:    color = grey(exp3(nib[3:1]), {8{nib[0]}});
			FMT_IA8:    color = grey(exp4(bytes[7:4]), exp4(bytes[3:0]));
			FMT_CI4,
			FMT_I4:     color = grey(exp4(nib), 8'hFF);
			FMT_CI8,
			FMT_I8:     color = grey(bytes[7:0], 8'hFF);
			default: begin
				color   = default_color;
				unknown = 1'b1;
			end
		endcase
	end

endmodule
`default_nettype wire

[rtl/core/texel_fetch_format_convert.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// texel_fetch_format_convert
// Texture memory with texel fetch and conversion to RGBA32 / RGBA16.
// ----------------------------------------------------------------------------
// A fetch result is offered after the input register, memory read,
// decode register and output register. Throughput: one item per cycle;
// the whole pipe holds while a result waits on m_tready.
// Reset: config registers clear; texture memory is cleared by a pass
// over its TMEM_BYTES/4 rows (1024 at default), s_tready low throughout.
// TMEM_BYTES must be a power of two.
module texel_fetch_format_convert import tffc_pkg::*; #(
	parameter int TMEM_BYTES = TFFC_TMEM_BYTES_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_we,
	input  wire [1:0]   cfg_index,
	input  wire [31:0]  cfg_data,
	input  wire         s_tvalid,
	output logic        s_tready,
	// mem_addr[11:0], write_size[13:12], write_data[45:14], coord_s[55:46],
	// coord_t[65:56], zero pad[71:66]
	input  wire [71:0]  s_tdata,
	// mode[0]
	input  wire         s_tuser,
	output logic        m_tvalid,
	input  wire         m_tready,
	// texel_rgba32[31:0], texel_rgba16[47:32]
	output logic [47:0] m_tdata,
	// format_unknown[0]
	output logic        m_tuser
);

	localparam int AW = $clog2(TMEM_BYTES);

	logic [11:0] tile_base_q;
	logic [11:0] tile_stride_q;
	logic [4:0]  tile_format_q;
	logic [31:0] default_color_q;

	logic        en;
	logic        accept;
	logic        busy;

	logic        v_s1;
	logic        mode_s1;
	logic [11:0] addr_s1;
	logic [1:0]  size_s1;
	logic [31:0] data_s1;
	logic [9:0]  s_s1;
	logic [21:0] prod_s1;

	logic        v_s2;
	tffc_fetch_t fetch_s2;
	logic        v_s3;
	logic [31:0] color_s3;
	logic        unk_s3;

	logic        out_v_q;
	logic [31:0] rgba32_q;
	logic [15:0] rgba16_q;
	logic        unk_q;

	logic [31:0] row_sum;
	logic [31:0] addr_sum;
	logic [31:0] wr_ext;
	logic        wr_en;
	logic [31:0] rd_bytes;
	logic [31:0] color;
	logic        unknown;

	assign en       = !out_v_q || m_tready;
	assign s_tready = en && !busy;
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tile_base_q     <= '0;
			tile_stride_q   <= '0;
			tile_format_q   <= '0;
			default_color_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_TILE_BASE:     tile_base_q     <= cfg_data[11:0];
				CFG_TILE_STRIDE:   tile_stride_q   <= cfg_data[11:0];
				CFG_TILE_FORMAT:   tile_format_q   <= cfg_data[4:0];
				CFG_DEFAULT_COLOR: default_color_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---- stage 1: input register, row offset product
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1 <= s_tuser;
			addr_s1 <= s_tdata[11:0];
			size_s1 <= s_tdata[13:12];
			data_s1 <= s_tdata[45:14];
			s_s1    <= s_tdata[55:46];
			prod_s1 <= 22'(s_tdata[65:56]) * 22'(tile_stride_q);
		end
	end

	// texel byte address, wrapped by taking the low bits
	always_comb begin
		row_sum = 32'(tile_base_q) + 32'(prod_s1);
		case (tile_format_q)
			FMT_RGBA16: addr_sum = row_sum + 32'({s_s1, 1'b0});
			FMT_RGBA32: addr_sum = 32'(tile_base_q) + 32'({prod_s1, 1'b0})
				+ 32'({s_s1, 2'b00});
			FMT_CI4,
			FMT_IA4,
			FMT_I4:     addr_sum = row_sum + 32'(s_s1[9:1]);
			default:    addr_sum = row_sum + 32'(s_s1);
		endcase
	end

	assign wr_ext = 32'(addr_s1);
	assign wr_en  = en && v_s1 && !mode_s1 && (size_s1 != 2'd3);

	tffc_tmem #(.TMEM_BYTES(TMEM_BYTES)) u_tmem (
		.clk     (clk),
		.arst_n  (arst_n),
		.busy    (busy),
		.wr_en   (wr_en),
		.wr_addr (wr_ext[AW-1:0]),
		.wr_size (size_s1),
		.wr_data (data_s1),
		.rd_en   (en),
		.rd_addr (addr_sum[AW-1:0]),
		.rd_data (rd_bytes)
	);

	// ---- stage 2: memory data back, decode
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1 && mode_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fetch_s2.fmt   <= tile_format_q;
			fetch_s2.s_odd <= s_s1[0];
		end
	end

	tffc_conv u_conv (
		.bytes         (rd_bytes),
		.fetch         (fetch_s2),
		.default_color (default_color_q),
		.color         (color),
		.unknown       (unknown)
	);

	// ---- stage 3: expanded colour
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			color_s3 <= color;
			unk_s3   <= unknown;
		end
	end

	// ---- output register, 5-5-5-1 repack
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en) begin
			out_v_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rgba32_q <= color_s3;
			rgba16_q <= pack16(color_s3);
			unk_q    <= unk_s3;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {rgba16_q, rgba32_q};
	assign m_tuser  = unk_q;

	// ---- assertions
	a_no_accept_clear: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !s_tready)
		else $error("input taken during memory clear");

	a_no_write_clear: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !wr_en)
		else $error("item write during memory clear");

	a_fetch_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(en && v_s1 && mode_s1) |=> v_s2)
		else $error("fetch lost between address and read stage");

	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_v_q) |-> $past(v_s3))
		else $error("result raised without a decoded fetch");

endmodule
`default_nettype wire
